// ----- rtl/core/sbhe_pkg.sv -----
package sbhe_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HashW   = 64;
  localparam int unsigned WordW   = 32;
  localparam int unsigned AlgoW   = 3;
  localparam int unsigned CfgIdxW = 1;

  // Algorithm constants
  localparam logic [HashW-1:0] Fnv64Basis = 64'hcbf2_9ce4_8422_2325;
  localparam logic [WordW-1:0] Fnv32Basis = 32'h811c_9dc5;
  localparam logic [WordW-1:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [WordW-1:0] AllOnes32  = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] DjbStart   = 32'd5381;

  // Algorithm select codes; the unused codes fall back to 64-bit FNV-1a.
  typedef enum logic [AlgoW-1:0] {
    AlgoFnv64 = 3'd0,
    AlgoFnv32 = 3'd1,
    AlgoCrc32 = 3'd2,
    AlgoDjb2  = 3'd3,
    AlgoSdbm  = 3'd4
  } algo_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgAlgoSel = 1'b0,
    CfgSeed    = 1'b1
  } cfg_idx_e;

  // Current configuration as seen by the datapath
  typedef struct packed {
    logic [AlgoW-1:0] algo_sel;
    logic [HashW-1:0] seed;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             byte_present;
    logic             end_of_message;
  } item_t;

endpackage

// ----- rtl/core/sbhe_in_if.sv -----
interface sbhe_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbhe_pkg::ByteW-1:0]   data_byte;
  logic                         byte_present;
  logic                         end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

// ----- rtl/core/sbhe_out_if.sv -----
interface sbhe_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbhe_pkg::HashW-1:0]   digest;

  modport source (output valid, output digest, input ready);
  modport sink   (input valid, input digest, output ready);
endinterface

// ----- rtl/core/sbhe_cfg_if.sv -----
interface sbhe_cfg_if;
  logic                         valid;
  logic                         ready;
  sbhe_pkg::cfg_idx_e           index;
  logic [sbhe_pkg::HashW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sbhe_cfg_regs.sv -----
module sbhe_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  sbhe_cfg_if.sink       cfg_i,
  output sbhe_pkg::cfg_t cfg_o
);
  import sbhe_pkg::*;

  logic [AlgoW-1:0] algo_sel_q;
  logic [HashW-1:0] seed_q;

  // The register file takes a write in every cycle.
  assign cfg_i.ready = 1'b1;

  // Register writes on each completed transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algo_sel_q <= '0;
      seed_q     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgAlgoSel: algo_sel_q <= cfg_i.data[AlgoW-1:0];
        CfgSeed:    seed_q     <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  assign cfg_o.algo_sel = algo_sel_q;
  assign cfg_o.seed     = seed_q;

endmodule

// ----- rtl/core/sbhe_datapath.sv -----
module sbhe_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  sbhe_pkg::item_t             item_i,
  input  sbhe_pkg::cfg_t              cfg_i,
  output logic [sbhe_pkg::HashW-1:0]  digest_o
);
  import sbhe_pkg::*;

  logic [HashW-1:0] hash_q, hash_d;
  logic             in_msg_q, in_msg_d;
  logic [HashW-1:0] base_hash;
  logic [HashW-1:0] absorbed;
  logic [WordW-1:0] seed32;
  logic [WordW-1:0] word;
  logic [WordW-1:0] crc_w;
  logic [WordW-1:0] fnv32_x;
  logic [HashW-1:0] fnv64_x;
  algo_e            algo;

  // Select codes beyond sdbm behave as 64-bit FNV-1a.
  always_comb begin
    case (cfg_i.algo_sel) inside
      AlgoFnv32, AlgoCrc32, AlgoDjb2, AlgoSdbm: algo = algo_e'(cfg_i.algo_sel);
      default:                                  algo = AlgoFnv64;
    endcase
  end

  assign seed32 = cfg_i.seed[WordW-1:0];

  // The start value is loaded at the first item of each message.
  always_comb begin
    if (in_msg_q) begin
      base_hash = hash_q;
    end else begin
      case (algo)
        AlgoFnv32: base_hash = {{(HashW-WordW){1'b0}}, Fnv32Basis ^ seed32};
        AlgoCrc32: base_hash = {{(HashW-WordW){1'b0}}, seed32 ^ AllOnes32};
        AlgoDjb2:  base_hash = {{(HashW-WordW){1'b0}}, DjbStart ^ seed32};
        AlgoSdbm:  base_hash = {{(HashW-WordW){1'b0}}, seed32};
        default:   base_hash = Fnv64Basis ^ cfg_i.seed;
      endcase
    end
  end

  assign word    = base_hash[WordW-1:0];
  assign fnv32_x = word ^ {{(WordW-ByteW){1'b0}}, item_i.data_byte};
  assign fnv64_x = base_hash ^ {{(HashW-ByteW){1'b0}}, item_i.data_byte};

  // Eight unrolled bit steps of the reflected CRC.
  always_comb begin
    crc_w = fnv32_x;
    for (int i = 0; i < ByteW; i++) begin
      crc_w = (crc_w >> 1) ^ (CrcPoly & {WordW{crc_w[0]}});
    end
  end

  // Absorb one byte; the FNV primes are applied as shift-and-add.
  always_comb begin
    case (algo)
      AlgoFnv32: absorbed = {{(HashW-WordW){1'b0}},
                             (fnv32_x << 24) + (fnv32_x << 8) + (fnv32_x << 7)
                             + (fnv32_x << 4) + (fnv32_x << 1) + fnv32_x};
      AlgoCrc32: absorbed = {{(HashW-WordW){1'b0}}, crc_w};
      AlgoDjb2:  absorbed = {{(HashW-WordW){1'b0}},
                             (word << 5) + word
                             + {{(WordW-ByteW){1'b0}}, item_i.data_byte}};
      AlgoSdbm:  absorbed = {{(HashW-WordW){1'b0}},
                             {{(WordW-ByteW){1'b0}}, item_i.data_byte}
                             + (word << 6) + (word << 16) - word};
      default:   absorbed = (fnv64_x << 40) + (fnv64_x << 8) + (fnv64_x << 7)
                            + (fnv64_x << 5) + (fnv64_x << 4) + (fnv64_x << 1)
                            + fnv64_x;
    endcase
  end

  assign hash_d   = item_i.byte_present ? absorbed : base_hash;
  assign in_msg_d = !item_i.end_of_message;

  // Finalize: CRC inverts its register, the 32-bit results are zero-extended.
  always_comb begin
    case (algo)
      AlgoFnv64: digest_o = hash_d;
      AlgoCrc32: digest_o = {{(HashW-WordW){1'b0}}, hash_d[WordW-1:0] ^ AllOnes32};
      default:   digest_o = {{(HashW-WordW){1'b0}}, hash_d[WordW-1:0]};
    endcase
  end

  // Running state advances once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q   <= '0;
      in_msg_q <= 1'b0;
    end else if (step_i) begin
      hash_q   <= hash_d;
      in_msg_q <= in_msg_d;
    end
  end

endmodule

// ----- rtl/core/selectable_byte_hash_engine_unit.sv -----
// Selectable byte hash engine.
// Bytes of a message enter on in_i, one per transfer, with byte_present and
// end_of_message flags. The digest of each message leaves on out_o as one
// transfer per item marked end_of_message; items not marked last give none.
// The cfg_i channel writes algorithm_select (index 0) and hash_seed
// (index 1); it is always ready and should be used only while the block is
// idle.
// Throughput is one byte per cycle while no last item waits for the output
// register. A byte passes through the input register, where the running hash
// is updated as it is processed, and the digest of a last item then goes to
// the output register, which drives out_o.valid. The running hash feedback
// through the combinational absorb logic sets this rate.
// When the receiver stalls, the output register holds its digest; bytes
// that close no message keep flowing, and the next last item waits in the
// input register until the output register frees up.
// Reset empties both registers and clears the running hash and the configuration
// (64-bit FNV-1a, seed zero); no message is open afterwards.
module selectable_byte_hash_engine_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbhe_cfg_if.sink  cfg_i,
  sbhe_in_if.sink   in_i,
  sbhe_out_if.source out_o
);
  import sbhe_pkg::*;

  cfg_t             cfg;
  item_t            item_q;
  logic             in_vld_q;
  logic             out_vld_q;
  logic [HashW-1:0] digest_q;
  logic [HashW-1:0] digest_d;
  logic             out_free;
  logic             step;

  sbhe_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // An item is processed once its digest, if any, has room to go.
  assign out_free   = !out_vld_q || out_o.ready;
  assign step       = in_vld_q && (!item_q.end_of_message || out_free);
  assign in_i.ready = !in_vld_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.data_byte      <= in_i.data_byte;
      item_q.byte_present   <= in_i.byte_present;
      item_q.end_of_message <= in_i.end_of_message;
    end
  end

  sbhe_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .digest_o (digest_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && item_q.end_of_message) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && item_q.end_of_message) begin
      digest_q <= digest_d;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.digest = digest_q;

endmodule

// ----- verif/sbhe_digest_checker.sv -----
`timescale 1ns / 100ps

// Watches the configuration, byte and digest channels of the hash engine.
// It keeps its own copy of the registers and the running hash and predicts
// the digest of every message. Each digest transfer is compared against the
// oldest predicted digest.
module sbhe_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbhe_cfg_if         cfg_mon_i,
  sbhe_in_if          in_mon_i,
  sbhe_out_if         out_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned digests_owed_o
);
  import sbhe_pkg::*;

  localparam logic [HashW-1:0] Fnv64Prime = 64'h0000_0100_0000_01b3;
  localparam logic [WordW-1:0] Fnv32Prime = 32'h0100_0193;

  // Shadow registers and hash state.
  logic [AlgoW-1:0] algo_sel_q;
  logic [HashW-1:0] seed_q;
  logic [HashW-1:0] running_digest;
  logic             message_open;

  // Digests predicted but not yet seen on the output channel, oldest first.
  logic [HashW-1:0] expected_digests[$];

  function automatic logic [HashW-1:0] widen(input logic [WordW-1:0] word);
    return {{(HashW-WordW){1'b0}}, word};
  endfunction

  // Codes above the last defined algorithm fall back to 64-bit FNV-1a.
  function automatic algo_e active_algo(input logic [AlgoW-1:0] sel);
    if (sel > AlgoSdbm) begin
      return AlgoFnv64;
    end
    return algo_e'(sel);
  endfunction

  // Start value of a message for the given algorithm and seed.
  function automatic logic [HashW-1:0] seeded_start(input algo_e algo,
                                                    input logic [HashW-1:0] seed);
    logic [WordW-1:0] seed_lo;
    seed_lo = seed[WordW-1:0];
    case (algo)
      AlgoFnv32: return widen(Fnv32Basis ^ seed_lo);
      AlgoCrc32: return widen(seed_lo ^ AllOnes32);
      AlgoDjb2:  return widen(DjbStart ^ seed_lo);
      AlgoSdbm:  return widen(seed_lo);
      default:   return Fnv64Basis ^ seed;
    endcase
  endfunction

  // Absorbs one byte into the running hash.
  function automatic logic [HashW-1:0] hash_byte(input algo_e algo,
                                                 input logic [HashW-1:0] state,
                                                 input logic [ByteW-1:0] data);
    logic [WordW-1:0] word;
    logic [WordW-1:0] data_w;
    word   = state[WordW-1:0];
    data_w = {{(WordW-ByteW){1'b0}}, data};
    case (algo)
      AlgoFnv32: return widen((word ^ data_w) * Fnv32Prime);
      AlgoCrc32: begin
        word = word ^ data_w;
        // Reflected CRC, one polynomial step per bit.
        for (int bit_idx = 0; bit_idx < ByteW; bit_idx++) begin
          word = word[0] ? ((word >> 1) ^ CrcPoly) : (word >> 1);
        end
        return widen(word);
      end
      AlgoDjb2:  return widen((word << 5) + word + data_w);
      AlgoSdbm:  return widen(data_w + (word << 6) + (word << 16) - word);
      default:   return (state ^ {{(HashW-ByteW){1'b0}}, data}) * Fnv64Prime;
    endcase
  endfunction

  // Turns the running hash into the digest that leaves the block.
  function automatic logic [HashW-1:0] finished_digest(input algo_e algo,
                                                       input logic [HashW-1:0] state);
    case (algo)
      AlgoFnv64: return state;
      AlgoCrc32: return widen(state[WordW-1:0] ^ AllOnes32);
      default:   return widen(state[WordW-1:0]);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [HashW-1:0] want;
    algo_e            algo;
    if (!rst_ni) begin
      algo_sel_q       = AlgoFnv64;
      seed_q           = '0;
      running_digest   = '0;
      message_open     = 1'b0;
      mismatch_count_o = 0;
      digests_owed_o   = 0;
      expected_digests.delete();
    end else begin
      // Register writes are to happen only while the block is idle; the user is bound, the block does not enforce it.
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          CfgAlgoSel: algo_sel_q = cfg_mon_i.data[AlgoW-1:0];
          CfgSeed:    seed_q     = cfg_mon_i.data;
          default:    ;
        endcase
      end

      // A digest transfer always belongs to an older item, so check it first.
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_digests.size() == 0) begin
          $display("%0t: digest %h arrived with no message closed", $time,
                   out_mon_i.digest);
          mismatch_count_o++;
        end else begin
          want = expected_digests.pop_front();
          if (out_mon_i.digest !== want) begin
            $display("%0t: digest mismatch: expected %h, actual %h", $time,
                     want, out_mon_i.digest);
            mismatch_count_o++;
          end
        end
      end

      // Advance the running hash on every byte channel transfer.
      if (in_mon_i.valid && in_mon_i.ready) begin
        algo = active_algo(algo_sel_q);
        if (!message_open) begin
          running_digest = seeded_start(algo, seed_q);
        end
        if (in_mon_i.byte_present) begin
          running_digest = hash_byte(algo, running_digest, in_mon_i.data_byte);
        end
        if (in_mon_i.end_of_message) begin
          expected_digests = {expected_digests, finished_digest(algo, running_digest)};
          message_open = 1'b0;
        end else begin
          message_open = 1'b1;
        end
      end

      digests_owed_o = expected_digests.size();
    end
  end

endmodule

// ----- verif/selectable_byte_hash_engine_unit_tb.sv -----
`timescale 1ns / 100ps

module selectable_byte_hash_engine_unit_tb;
  import sbhe_pkg::*;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned owed;
  int unsigned sent_items;
  int unsigned lost_digests;
  bit          no_gaps;

  sbhe_cfg_if cfg_ch ();
  sbhe_in_if  byte_ch ();
  sbhe_out_if digest_ch ();

  selectable_byte_hash_engine_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (byte_ch),
    .out_o  (digest_ch)
  );

  sbhe_digest_checker digest_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_mon_i        (cfg_ch),
    .in_mon_i         (byte_ch),
    .out_mon_i        (digest_ch),
    .mismatch_count_o (mismatches),
    .digests_owed_o   (owed)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Digest receiver: bursts of ready broken by stalls of random length.
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    digest_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      stall_len = pick_pause();
      digest_ch.ready = 1'b1;
      repeat (run_len) @(negedge clk);
      if (stall_len != 0) begin
        digest_ch.ready = 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  // One transfer on the byte channel, after an optional pause.
  task automatic send_item(input logic [ByteW-1:0] data, input logic present,
                           input logic last);
    int unsigned pause;
    pause = no_gaps ? 0 : pick_pause();
    if (pause != 0) begin
      byte_ch.valid = 1'b0;
      repeat (pause) @(negedge clk);
    end
    byte_ch.data_byte      = data;
    byte_ch.byte_present   = present;
    byte_ch.end_of_message = last;
    byte_ch.valid          = 1'b1;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Holds the byte channel until every digest is out and the pipe is empty.
  task automatic drain_digests();
    byte_ch.valid = 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [HashW-1:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Upper bits of the algorithm write carry noise; only the low bits count.
  task automatic apply_setting(input logic [AlgoW-1:0] algo,
                               input logic [HashW-1:0] seed);
    logic [HashW-1:0] sel_word;
    drain_digests();
    sel_word = {$urandom, $urandom};
    sel_word[AlgoW-1:0] = algo;
    write_reg(CfgAlgoSel, sel_word);
    write_reg(CfgSeed, seed);
  endtask

  // A message of random bytes, sometimes with empty items mixed in and
  // sometimes closed by an empty last item.
  task automatic send_message(input int unsigned len);
    bit empty_close;
    empty_close = (len == 0) || ($urandom_range(0, 4) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(ByteW'($urandom), 1'b0, 1'b0);
      end
      send_item(ByteW'($urandom), 1'b1, !empty_close && (k == len - 1));
    end
    if (empty_close) begin
      send_item(ByteW'($urandom), 1'b0, 1'b1);
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)  return 0;
    if (roll < 80) return $urandom_range(1, 8);
    if (roll < 95) return $urandom_range(9, 24);
    return $urandom_range(25, 64);
  endfunction

  initial begin
    logic [HashW-1:0] seed;
    int unsigned      phase_start;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = CfgAlgoSel;
    cfg_ch.data            = '0;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = '0;
    byte_ch.byte_present   = 1'b0;
    byte_ch.end_of_message = 1'b0;
    sent_items             = 0;
    lost_digests           = 0;
    no_gaps                = 1'b0;
    rst_n                  = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset configuration: empty message with no message open, then the
    // extreme single-byte messages.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);

    // Items without a byte: the first opens the message, the second changes
    // nothing, then a byte is absorbed and an empty last item closes it.
    send_item(8'h3c, 1'b0, 1'b0);
    send_item(8'hc3, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);

    apply_setting(AlgoFnv32, '1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    apply_setting(AlgoCrc32, '0);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h32, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b1);

    apply_setting(AlgoDjb2, {$urandom, $urandom});
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);

    apply_setting(AlgoSdbm, '1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);

    // Unused selector code behaves as 64-bit FNV-1a.
    apply_setting(3'd7, 64'h8000_0000_0000_0001);
    send_item(8'h7f, 1'b1, 1'b1);

    // Registers change while a message is open; the hash is not reloaded.
    apply_setting(AlgoCrc32, {$urandom, $urandom});
    send_item(8'h55, 1'b1, 1'b0);
    apply_setting(AlgoSdbm, {$urandom, $urandom});
    send_item(8'haa, 1'b1, 1'b1);

    // Random phases, each under its own setting; every selector code and
    // the seed extremes come up.
    for (int unsigned phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0:       seed = '0;
        1:       seed = '1;
        2:       seed = {$urandom, $urandom};
        default: seed = {32'h0, $urandom};
      endcase
      apply_setting((phase < 8) ? phase[AlgoW-1:0] : AlgoW'($urandom_range(0, 7)), seed);
      no_gaps     = (phase % 3 == 2);
      phase_start = sent_items;
      while (sent_items - phase_start < 70) begin
        send_message(pick_length());
        // Now and then the sender waits for every digest to come out.
        if ($urandom_range(0, 99) < 4) begin
          drain_digests();
        end
      end
    end

    // Wait for the remaining digests, with a limit.
    byte_ch.valid = 1'b0;
    for (int unsigned w = 0; w < 20000 && owed != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (owed != 0) begin
      $display("%0t: %0d expected digests never arrived", $time, owed);
      lost_digests = owed;
    end

    if (mismatches == 0 && lost_digests == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
